// ----- design/ecc_pkg.sv -----
// shared types, constants and calendar helpers for the epoch calendar converter
package ecc_pkg;

  // operation codes
  localparam logic OP_TO_SECS = 1'b0;
  localparam logic OP_TO_CAL  = 1'b1;

  // calendar constants
  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [11:0] CENTURY_YEAR     = 12'd2100;
  localparam logic [13:0] SET_YEAR_MIN     = 14'd2000;
  localparam logic [13:0] SET_YEAR_MAX     = 14'd2099;
  localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
  localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN     = 32'd60;
  localparam logic [31:0] DAYS_PER_WEEK    = 32'd7;
  localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [3:0]  LAST_MONTH0      = 4'd11;
  localparam logic [15:0] WEEKDAY_OFFSET   = 16'd4;

  // rounded-up reciprocals, exact over the operand ranges that reach them
  // day: (count >> 7) / 675 with a 35-bit shift
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  // hour: (rem >> 4) / 225 with a 21-bit shift
  localparam logic [13:0] RECIP_HOUR = 14'd9321;
  // minute: (rem >> 2) / 15 with a 14-bit shift
  localparam logic [10:0] RECIP_MIN  = 11'd1093;
  // week: (days + 4) / 7 with a 19-bit shift
  localparam logic [16:0] RECIP_WEEK = 17'd74899;

  typedef struct packed {
    logic        operation;
    logic [31:0] count_in;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
    logic        range_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_YEAR,
    ST_SET_MONTH,
    ST_SET_DAY,
    ST_SET_HOUR,
    ST_SET_MINSEC,
    ST_DIV,
    ST_DIV_SAVE,
    ST_GET_YEAR,
    ST_GET_MONTH,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_YEAR,
    DP_SET_MONTH,
    DP_SET_DAY,
    DP_SET_HOUR,
    DP_SET_MINSEC,
    DP_DIV_STEP,
    DP_DIV_SAVE,
    DP_GET_YEAR,
    DP_GET_MONTH,
    DP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_HOUR,
    DV_MIN,
    DV_WEEK
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic to_cal;
    logic range_bad;
    logic year_done;
    logic month_done;
  } dp_status_t;

  // leap rule over 1970..2106, where 2100 is the only century year that is not a leap year
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != CENTURY_YEAR);
  endfunction

  // length of zero-based month m0
  function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
    logic [4:0] d;
    unique case (m0)
      4'd1:                   d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  // seconds in a month of the given length
  function automatic logic [31:0] month_secs(input logic [4:0] dim);
    logic [31:0] s;
    unique case (dim)
      5'd28:   s = 32'd2419200;
      5'd29:   s = 32'd2505600;
      5'd30:   s = 32'd2592000;
      default: s = 32'd2678400;
    endcase
    return s;
  endfunction

endpackage

// ----- design/ecc_dp.sv -----
// datapath: operand registers, accumulator, reciprocal dividers and result register
module ecc_dp import ecc_pkg::*; (
  input  logic       clk,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_data
);

  in_item_t    in_r, in_nxt;
  out_item_t   out_r, out_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  m0_r, m0_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] days_r, days_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  weekday_r, weekday_nxt;

  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  dim;
  logic [3:0]  month_c;
  logic [4:0]  day_c;
  logic        to_cal;
  logic        range_bad;
  logic        year_done;
  logic        month_done;
  logic [31:0] day_term;
  logic [31:0] hour_term;
  logic [31:0] minsec_term;
  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [32:0] week_prod;
  logic [15:0] quot_c;
  logic [31:0] quot_back;
  logic [31:0] rem_c;

  // calendar helpers on the current year and month
  always_comb begin
    leap     = is_leap(year_r);
    year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    dim      = month_len(m0_r, leap);
  end

  // clamped calendar inputs and range check
  always_comb begin
    if (in_r.month_in == 4'd0) begin
      month_c = 4'd1;
    end else if (in_r.month_in > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = in_r.month_in;
    end
    day_c     = (in_r.day_in == 5'd0) ? 5'd1 : in_r.day_in;
    to_cal    = (in_r.operation == OP_TO_CAL);
    range_bad = (in_r.year_in < SET_YEAR_MIN) || (in_r.year_in > SET_YEAR_MAX);
  end

  // loop exit tests for both directions, on shared status bits
  always_comb begin
    if (to_cal) begin
      year_done  = left_r < {7'd0, year_len};
      month_done = (m0_r == LAST_MONTH0) || (left_r < {11'd0, dim});
    end else begin
      year_done  = {2'd0, year_r} == in_r.year_in;
      month_done = (m0_r + 4'd1) >= month_c;
    end
  end

  assign status = '{to_cal: to_cal, range_bad: range_bad,
                    year_done: year_done, month_done: month_done};

  // time-of-day terms, one multiply each
  always_comb begin
    day_term    = 32'(day_c - 5'd1) * SECS_PER_DAY;
    hour_term   = 32'(in_r.hour_in) * SECS_PER_HOUR;
    minsec_term = 32'(in_r.minute_in) * SECS_PER_MIN + 32'(in_r.second_in);
  end

  // quotient by reciprocal multiply, low divisor bits shifted out first
  always_comb begin
    day_prod  = 51'(num_r[31:7]) * 51'(RECIP_DAY);
    hour_prod = 27'(num_r[16:4]) * 27'(RECIP_HOUR);
    min_prod  = 21'(num_r[11:2]) * 21'(RECIP_MIN);
    week_prod = 33'(num_r[15:0]) * 33'(RECIP_WEEK);
    case (cmd.sel)
      DV_DAY:  quot_c = day_prod[50:35];
      DV_HOUR: quot_c = {10'd0, hour_prod[26:21]};
      DV_MIN:  quot_c = {9'd0, min_prod[20:14]};
      default: quot_c = {2'd0, week_prod[32:19]};
    endcase
  end

  // remainder from the registered quotient
  always_comb begin
    case (cmd.sel)
      DV_DAY:  quot_back = 32'(quot_r) * SECS_PER_DAY;
      DV_HOUR: quot_back = 32'(quot_r) * SECS_PER_HOUR;
      DV_MIN:  quot_back = 32'(quot_r) * SECS_PER_MIN;
      default: quot_back = 32'(quot_r) * DAYS_PER_WEEK;
    endcase
    rem_c = num_r - quot_back;
  end

  // command decode
  always_comb begin
    in_nxt      = in_r;
    out_nxt     = out_r;
    acc_nxt     = acc_r;
    year_nxt    = year_r;
    m0_nxt      = m0_r;
    left_nxt    = left_r;
    days_nxt    = days_r;
    num_nxt     = num_r;
    quot_nxt    = quot_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    weekday_nxt = weekday_r;
    unique case (cmd.op)
      DP_LOAD: begin
        in_nxt   = in_data;
        acc_nxt  = 32'd0;
        year_nxt = EPOCH_YEAR;
        m0_nxt   = 4'd0;
        num_nxt  = in_data.count_in;
        quot_nxt = 16'd0;
      end
      DP_SET_YEAR: begin
        if (!year_done) begin
          acc_nxt  = acc_r + (leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR);
          year_nxt = year_r + 12'd1;
        end
      end
      DP_SET_MONTH: begin
        if (!month_done) begin
          acc_nxt = acc_r + month_secs(dim);
          m0_nxt  = m0_r + 4'd1;
        end
      end
      DP_SET_DAY: begin
        acc_nxt = acc_r + day_term;
      end
      DP_SET_HOUR: begin
        acc_nxt = acc_r + hour_term;
      end
      DP_SET_MINSEC: begin
        acc_nxt = acc_r + minsec_term;
      end
      DP_DIV_STEP: begin
        quot_nxt = quot_c;
      end
      DP_DIV_SAVE: begin
        case (cmd.sel)
          DV_DAY: begin
            days_nxt = quot_r;
            left_nxt = quot_r;
            num_nxt  = rem_c;
          end
          DV_HOUR: begin
            hour_nxt = quot_r[4:0];
            num_nxt  = rem_c;
          end
          DV_MIN: begin
            minute_nxt = quot_r[5:0];
            second_nxt = rem_c[5:0];
            num_nxt    = 32'(days_r + WEEKDAY_OFFSET);
          end
          default: begin
            weekday_nxt = rem_c[2:0];
          end
        endcase
      end
      DP_GET_YEAR: begin
        if (!year_done) begin
          left_nxt = left_r - 16'(year_len);
          year_nxt = year_r + 12'd1;
        end
      end
      DP_GET_MONTH: begin
        if (!month_done) begin
          left_nxt = left_r - 16'(dim);
          m0_nxt   = m0_r + 4'd1;
        end
      end
      DP_OUT: begin
        out_nxt = '0;
        if (to_cal) begin
          out_nxt.year_out    = year_r;
          out_nxt.month_out   = m0_r + 4'd1;
          out_nxt.day_out     = left_r[4:0] + 5'd1;
          out_nxt.hour_out    = hour_r;
          out_nxt.minute_out  = minute_r;
          out_nxt.second_out  = second_r;
          out_nxt.weekday_out = weekday_r;
          out_nxt.range_error = {2'd0, year_r} > SET_YEAR_MAX;
        end else begin
          out_nxt.count_out   = range_bad ? 32'd0 : acc_r;
          out_nxt.range_error = range_bad;
        end
      end
      default: begin
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    out_r     <= out_nxt;
    acc_r     <= acc_nxt;
    year_r    <= year_nxt;
    m0_r      <= m0_nxt;
    left_r    <= left_nxt;
    days_r    <= days_nxt;
    num_r     <= num_nxt;
    quot_r    <= quot_nxt;
    hour_r    <= hour_nxt;
    minute_r  <= minute_nxt;
    second_r  <= second_nxt;
    weekday_r <= weekday_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- design/ecc_ctrl.sv -----
// controller: sequences the conversion steps and owns the handshakes
module ecc_ctrl import ecc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  div_sel_t    sel_r, sel_nxt;
  logic        out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = DP_NOP;
    cmd.sel       = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.to_cal) begin
          sel_nxt   = DV_DAY;
          state_nxt = ST_DIV;
        end else if (status.range_bad) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SET_YEAR;
        end
      end
      ST_SET_YEAR: begin
        cmd.op = DP_SET_YEAR;
        if (status.year_done) begin
          state_nxt = ST_SET_MONTH;
        end
      end
      ST_SET_MONTH: begin
        cmd.op = DP_SET_MONTH;
        if (status.month_done) begin
          state_nxt = ST_SET_DAY;
        end
      end
      ST_SET_DAY: begin
        cmd.op    = DP_SET_DAY;
        state_nxt = ST_SET_HOUR;
      end
      ST_SET_HOUR: begin
        cmd.op    = DP_SET_HOUR;
        state_nxt = ST_SET_MINSEC;
      end
      ST_SET_MINSEC: begin
        cmd.op    = DP_SET_MINSEC;
        state_nxt = ST_FINISH;
      end
      ST_DIV: begin
        cmd.op    = DP_DIV_STEP;
        state_nxt = ST_DIV_SAVE;
      end
      ST_DIV_SAVE: begin
        cmd.op = DP_DIV_SAVE;
        unique case (sel_r)
          DV_DAY: begin
            sel_nxt   = DV_HOUR;
            state_nxt = ST_DIV;
          end
          DV_HOUR: begin
            sel_nxt   = DV_MIN;
            state_nxt = ST_DIV;
          end
          DV_MIN: begin
            sel_nxt   = DV_WEEK;
            state_nxt = ST_DIV;
          end
          default: begin
            state_nxt = ST_GET_YEAR;
          end
        endcase
      end
      ST_GET_YEAR: begin
        cmd.op = DP_GET_YEAR;
        if (status.year_done) begin
          state_nxt = ST_GET_MONTH;
        end
      end
      ST_GET_MONTH: begin
        cmd.op = DP_GET_MONTH;
        if (status.month_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= DV_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // a result appears only when leaving the finish state
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result valid raised outside finish");

  // each quotient step is followed by its remainder step
  a_div_save: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV_SAVE))
    else $error("quotient step not followed by save");

  // an accepted item is dispatched next cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_DISPATCH))
    else $error("accepted item not dispatched");

  // a free output slot is filled straight from finish
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finish did not deliver result");

endmodule

// ----- design/epoch_calendar_converter_top.sv -----
// top level of the epoch calendar converter: controller plus datapath
// one item at a time; next item taken the cycle after the result is registered or a stall clears
// calendar to seconds: year walk from 1970, month walk, then day, hour and minute-second adds
// seconds to calendar: four reciprocal divisions (day, hour, minute, weekday), each a quotient
// step and a remainder step, then the year and month walk loops; a rejected year goes to finish
// synchronous active-low reset clears the controller and the output valid; payload is not reset
module epoch_calendar_converter_top import ecc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and result register
  ecc_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ----- bench/epoch_calendar_converter_top_test.sv -----
`timescale 1ns / 1ps
// testbench for the epoch calendar converter: directed date table, then random items against a predictor
module epoch_calendar_converter_top_test;
  import ecc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int          TABLE_ROWS   = 21;
  localparam out_item_t   NO_RESULT    = '0;

  // one row of the directed table: stimulus, whether the result is typed in, the result
  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t result;
  } table_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  out_item_t   pending_results[$];
  table_row_t  directed_table [TABLE_ROWS];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on;

  epoch_calendar_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // full gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // days in zero-based month m0 of year y
  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m0);
    case (m0)
      1:           return leap_year(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // expected conversion result for one item
  function automatic out_item_t predict_conversion(input in_item_t it);
    out_item_t       r;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     dy;
    int unsigned     days;
    int unsigned     left;
    int unsigned     rem;
    int unsigned     m0;
    longint unsigned secs;
    r = '0;
    if (it.operation == OP_TO_SECS) begin
      yr = 32'(it.year_in);
      if (yr < 32'(SET_YEAR_MIN) || yr > 32'(SET_YEAR_MAX)) begin
        r.range_error = 1'b1;
        return r;
      end
      // out-of-range month and day zero are clamped
      mon = 32'(it.month_in);
      dy  = 32'(it.day_in);
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      if (dy < 1) dy = 1;
      secs = 0;
      for (int unsigned y = 1970; y < yr; y++)
        secs += leap_year(y) ? 64'd31622400 : 64'd31536000;
      for (int unsigned m = 0; m + 1 < mon; m++)
        secs += 64'(days_of_month(yr, m)) * 86400;
      secs += 64'(dy - 1) * 86400;
      secs += 64'(it.hour_in) * 3600 + 64'(it.minute_in) * 60 + 64'(it.second_in);
      r.count_out = secs[31:0];
    end else begin
      days = it.count_in / 86400;
      rem  = it.count_in % 86400;
      left = days;
      yr   = 1970;
      while (left >= (leap_year(yr) ? 366 : 365)) begin
        left -= leap_year(yr) ? 366 : 365;
        yr++;
      end
      m0 = 0;
      while (m0 < 11 && left >= days_of_month(yr, m0)) begin
        left -= days_of_month(yr, m0);
        m0++;
      end
      r.year_out    = 12'(yr);
      r.month_out   = 4'(m0 + 1);
      r.day_out     = 5'(left + 1);
      r.hour_out    = 5'(rem / 3600);
      r.minute_out  = 6'((rem % 3600) / 60);
      r.second_out  = 6'(rem % 60);
      r.weekday_out = 3'((days + 4) % 7);
      r.range_error = (yr > 2099);
    end
    return r;
  endfunction

  // calendar-to-seconds item
  function automatic in_item_t set_item(input int unsigned y, input int unsigned mo,
                                        input int unsigned d, input int unsigned h,
                                        input int unsigned mi, input int unsigned s);
    in_item_t it;
    it           = '0;
    it.operation = OP_TO_SECS;
    it.year_in   = 14'(y);
    it.month_in  = 4'(mo);
    it.day_in    = 5'(d);
    it.hour_in   = 5'(h);
    it.minute_in = 6'(mi);
    it.second_in = 6'(s);
    return it;
  endfunction

  // seconds-to-calendar item
  function automatic in_item_t count_item(input logic [31:0] cnt);
    in_item_t it;
    it           = '0;
    it.operation = OP_TO_CAL;
    it.count_in  = cnt;
    return it;
  endfunction

  function automatic out_item_t secs_result(input logic [31:0] cnt, input logic err);
    out_item_t r;
    r             = '0;
    r.count_out   = cnt;
    r.range_error = err;
    return r;
  endfunction

  function automatic out_item_t date_result(input int unsigned y, input int unsigned mo,
                                            input int unsigned d, input int unsigned h,
                                            input int unsigned mi, input int unsigned s,
                                            input int unsigned wd, input logic err);
    out_item_t r;
    r             = '0;
    r.year_out    = 12'(y);
    r.month_out   = 4'(mo);
    r.day_out     = 5'(d);
    r.hour_out    = 5'(h);
    r.minute_out  = 6'(mi);
    r.second_out  = 6'(s);
    r.weekday_out = 3'(wd);
    r.range_error = err;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random item: mostly well-formed dates and boundary counts, some raw bits
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    int unsigned y;
    int unsigned mo;
    out_item_t   month_start;
    it.operation = 1'($urandom);
    it.count_in  = $urandom;
    it.year_in   = 14'($urandom);
    it.month_in  = 4'($urandom);
    it.day_in    = 5'($urandom);
    it.hour_in   = 5'($urandom);
    it.minute_in = 6'($urandom);
    it.second_in = 6'($urandom);
    r = $urandom_range(0, 99);
    if (it.operation == OP_TO_SECS) begin
      if (r < 90) begin
        y = (r < 80) ? $urandom_range(2000, 2099) : $urandom_range(1990, 2110);
        it.year_in = 14'(y);
        // valid year with raw time fields between 60 and 79
        if (r < 60 || r >= 80) begin
          mo           = $urandom_range(1, 12);
          it.month_in  = 4'(mo);
          it.day_in    = 5'($urandom_range(1, days_of_month(y, mo - 1)));
          it.hour_in   = 5'($urandom_range(0, 23));
          it.minute_in = 6'($urandom_range(0, 59));
          it.second_in = 6'($urandom_range(0, 59));
        end
      end
    end else begin
      if (r < 25) begin
        it.count_in = $urandom_range(0, 49709) * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
      end else if (r < 50) begin
        // first second of a month, or the last second before it
        month_start = predict_conversion(set_item($urandom_range(2000, 2099),
                                                  $urandom_range(1, 12), 1, 0, 0, 0));
        it.count_in = month_start.count_out - $urandom_range(0, 1);
      end else if (r < 60) begin
        it.count_in = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      end
    end
    return it;
  endfunction

  // offer one item at a falling edge, wait for acceptance, then idle for a picked gap, which may be none
  task automatic drive_item(input in_item_t it, input out_item_t result);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(result);
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // compare one result item with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result item with none expected: %h", got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.count_out !== want.count_out) begin
      $error("count_out expected %0d actual %0d", want.count_out, got.count_out);
      mismatch_count++;
    end
    if (got.year_out !== want.year_out) begin
      $error("year_out expected %0d actual %0d", want.year_out, got.year_out);
      mismatch_count++;
    end
    if (got.month_out !== want.month_out) begin
      $error("month_out expected %0d actual %0d", want.month_out, got.month_out);
      mismatch_count++;
    end
    if (got.day_out !== want.day_out) begin
      $error("day_out expected %0d actual %0d", want.day_out, got.day_out);
      mismatch_count++;
    end
    if (got.hour_out !== want.hour_out) begin
      $error("hour_out expected %0d actual %0d", want.hour_out, got.hour_out);
      mismatch_count++;
    end
    if (got.minute_out !== want.minute_out) begin
      $error("minute_out expected %0d actual %0d", want.minute_out, got.minute_out);
      mismatch_count++;
    end
    if (got.second_out !== want.second_out) begin
      $error("second_out expected %0d actual %0d", want.second_out, got.second_out);
      mismatch_count++;
    end
    if (got.weekday_out !== want.weekday_out) begin
      $error("weekday_out expected %0d actual %0d", want.weekday_out, got.weekday_out);
      mismatch_count++;
    end
    if (got.range_error !== want.range_error) begin
      $error("range_error expected %0b actual %0b", want.range_error, got.range_error);
      mismatch_count++;
    end
  endtask

  // result side: random stall stretches
  initial begin
    int unsigned hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) check_result(out_data);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[epoch_calendar_converter_top] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    idle_on  = 1'b1;

    // calendar to seconds: bounds, rejected years, clamped fields
    directed_table[0]  = {set_item(2000, 1, 1, 0, 0, 0), 1'b1, secs_result(32'd946684800, 1'b0)};
    directed_table[1]  = {set_item(1999, 12, 31, 23, 59, 59), 1'b1, secs_result(32'd0, 1'b1)};
    directed_table[2]  = {set_item(2100, 1, 1, 0, 0, 0), 1'b1, secs_result(32'd0, 1'b1)};
    directed_table[3]  = {set_item(0, 0, 0, 0, 0, 0), 1'b1, secs_result(32'd0, 1'b1)};
    directed_table[4]  = {set_item(16383, 15, 31, 31, 63, 63), 1'b1, secs_result(32'd0, 1'b1)};
    directed_table[5]  = {set_item(2099, 12, 31, 23, 59, 59), 1'b1,
                          secs_result(32'd4102444799, 1'b0)};
    directed_table[6]  = {set_item(2000, 2, 29, 12, 0, 0), 1'b0, NO_RESULT};
    directed_table[7]  = {set_item(2024, 0, 0, 0, 0, 0), 1'b0, NO_RESULT};
    directed_table[8]  = {set_item(2024, 15, 31, 31, 63, 63), 1'b0, NO_RESULT};
    directed_table[9]  = {set_item(2001, 2, 31, 0, 0, 0), 1'b0, NO_RESULT};
    // seconds to calendar: extremes, the edge from 2099 into 2100, leap days and leap year ends
    directed_table[10] = {count_item(32'd0), 1'b1, date_result(1970, 1, 1, 0, 0, 0, 4, 1'b0)};
    directed_table[11] = {count_item(32'hFFFF_FFFF), 1'b1,
                          date_result(2106, 2, 7, 6, 28, 15, 0, 1'b1)};
    directed_table[12] = {count_item(32'd4102444799), 1'b1,
                          date_result(2099, 12, 31, 23, 59, 59, 4, 1'b0)};
    directed_table[13] = {count_item(32'd4102444800), 1'b1,
                          date_result(2100, 1, 1, 0, 0, 0, 5, 1'b1)};
    directed_table[14] = {count_item(32'd978220800), 1'b0, NO_RESULT};
    directed_table[15] = {count_item(32'd978307199), 1'b0, NO_RESULT};
    directed_table[16] = {count_item(32'd951782400), 1'b0, NO_RESULT};
    directed_table[17] = {count_item(32'd4107542399), 1'b0, NO_RESULT};
    directed_table[18] = {count_item(32'd4107542400), 1'b0, NO_RESULT};
    directed_table[19] = {count_item(32'd1104537599), 1'b0, NO_RESULT};
    directed_table[20] = {count_item(32'd68169600), 1'b0, NO_RESULT};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < TABLE_ROWS; i++) begin
      drive_item(directed_table[i].stim,
                 directed_table[i].known ? directed_table[i].result
                                         : predict_conversion(directed_table[i].stim));
    end

    // random items, with idling switched off for stretches
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 149) == 0) idle_on = !idle_on;
      it = random_item();
      drive_item(it, predict_conversion(it));
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[epoch_calendar_converter_top] OK");
    end else begin
      $display("[epoch_calendar_converter_top] ERROR");
    end
    $finish;
  end

endmodule
